>>> rtl/core/id_occurrence_counter_with_mode_unit_assert.svh
// assertion macros for the occurrence counter core
`ifndef ID_OCCURRENCE_COUNTER_WITH_MODE_UNIT_ASSERT_SVH
`define ID_OCCURRENCE_COUNTER_WITH_MODE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IOC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ioc assertion failed");
`define IOC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ioc assertion failed");
`else
`define IOC_ASSERT_SAME(lbl, ante, cons)
`define IOC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/ioc_pkg.sv
// shared constants and types for the occurrence counter core
`timescale 1ns / 1ps
`default_nettype none
package ioc_pkg;
    localparam int TABLE_DEPTH    = 64;
    localparam int COUNT_BITS     = 16;
    localparam int KEY_BITS       = 32;
    localparam int OUT_COUNT_BITS = 16;
    localparam int IDX_BITS       = $clog2(TABLE_DEPTH);
    localparam int USED_BITS      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_BITS     = KEY_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // request to the mode tracker
    typedef struct packed {
        logic                  clear;
        logic                  valid;
        logic [KEY_BITS-1:0]   id;
        logic [COUNT_BITS-1:0] cnt;
    } mode_upd_t;
endpackage
`default_nettype wire

>>> rtl/core/id_occurrence_counter_with_mode_unit.sv
// occurrence counter top: scan sequencer, table memory and mode tracker
//
//  channel | direction | beat fields
//  in      | in        | item_id, start_new
//  out     | out       | was_present, id_count, best_id, best_count, best_valid,
//          |           | table_full_drop
//
// a beat runs from accept through the scan, write and done states; the result is loaded into
// the output as the unit returns to idle, before the next accept
// one key comparator walks the stored entries, one per cycle from the registered ram read
// reset clears the fill count and the mode; table entries need no clearing
// a finished result waits in the output register while the next beat is taken
// in_stall is high from the accept until the result is loaded into the output
`timescale 1ns / 1ps
`default_nettype none
module id_occurrence_counter_with_mode_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ioc_pkg::KEY_BITS-1:0]      item_id,
    input  wire logic                              start_new,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   was_present,
    output logic      [ioc_pkg::OUT_COUNT_BITS-1:0] id_count,
    output logic      [ioc_pkg::KEY_BITS-1:0]      best_id,
    output logic      [ioc_pkg::OUT_COUNT_BITS-1:0] best_count,
    output logic                                   best_valid,
    output logic                                   table_full_drop
);
    import ioc_pkg::*;
    `include "id_occurrence_counter_with_mode_unit_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [KEY_BITS-1:0]     id_reg, id_next;
    logic [USED_BITS-1:0]    used_reg, used_next;
    logic [USED_BITS-1:0]    scan_idx_reg, scan_idx_next;
    logic                    pend_reg, pend_next;
    logic [IDX_BITS-1:0]     pend_idx_reg, pend_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_BITS-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                    drop_reg, drop_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      was_present_reg, was_present_next;
    logic [OUT_COUNT_BITS-1:0] id_count_reg, id_count_next;
    logic [KEY_BITS-1:0]       best_id_reg, best_id_next;
    logic [OUT_COUNT_BITS-1:0] best_count_reg, best_count_next;
    logic                      best_valid_reg, best_valid_next;
    logic                      drop_out_reg, drop_out_next;

    logic                    ram_we, ram_re;
    logic [IDX_BITS-1:0]     ram_waddr, ram_raddr;
    logic [ENTRY_BITS-1:0]   ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0]     rd_key;
    logic [COUNT_BITS-1:0]   rd_count;
    logic                    key_hit;
    logic                    in_take;
    logic                    out_free;
    mode_upd_t               mode_upd;
    logic [KEY_BITS-1:0]     mode_id;
    logic [COUNT_BITS-1:0]   mode_count;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_key   = ram_rdata[ENTRY_BITS-1:COUNT_BITS];
    assign rd_count = ram_rdata[COUNT_BITS-1:0];
    // shared key comparator, looks at the entry read in the previous cycle
    assign key_hit  = pend_reg && (rd_key == id_reg);

    ioc_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_BITS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ioc_mode_track u_mode (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (mode_upd),
        .mode_id    (mode_id),
        .mode_count (mode_count)
    );

    always_comb
    begin
        state_next       = state_reg;
        id_next          = id_reg;
        used_next        = used_reg;
        scan_idx_next    = scan_idx_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        cnt_next         = cnt_reg;
        drop_next        = drop_reg;
        out_valid_next   = out_valid_reg;
        was_present_next = was_present_reg;
        id_count_next    = id_count_reg;
        best_id_next     = best_id_reg;
        best_count_next  = best_count_reg;
        best_valid_next  = best_valid_reg;
        drop_out_next    = drop_out_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = scan_idx_reg[IDX_BITS-1:0];
        ram_waddr        = hit_reg ? hit_idx_reg : used_reg[IDX_BITS-1:0];
        ram_wdata        = {id_reg, cnt_reg};
        mode_upd.clear   = 1'b0;
        mode_upd.valid   = 1'b0;
        mode_upd.id      = id_reg;
        mode_upd.cnt     = cnt_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    id_next        = item_id;
                    scan_idx_next  = '0;
                    pend_next      = 1'b0;
                    mode_upd.clear = start_new;
                    if (start_new)
                    begin
                        used_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (key_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    drop_next    = 1'b0;
                    cnt_next     = (rd_count == COUNT_MAX) ? rd_count
                                                           : rd_count + 1'b1;
                    pend_next    = 1'b0;
                    state_next   = ST_WRITE;
                end
                else if (scan_idx_reg < used_reg)
                begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IDX_BITS-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    // last entry read did not match
                    pend_next = 1'b0;
                end
                else
                begin
                    hit_next   = 1'b0;
                    drop_next  = (used_reg == USED_BITS'(TABLE_DEPTH));
                    cnt_next   = (used_reg == USED_BITS'(TABLE_DEPTH))
                                 ? '0 : COUNT_BITS'(1);
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!drop_reg)
                begin
                    ram_we         = 1'b1;
                    mode_upd.valid = 1'b1;
                    if (!hit_reg)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    was_present_next = hit_reg;
                    id_count_next    = OUT_COUNT_BITS'(cnt_reg);
                    best_valid_next  = (used_reg != '0);
                    best_id_next     = (used_reg != '0) ? mode_id : '0;
                    best_count_next  = (used_reg != '0)
                                       ? OUT_COUNT_BITS'(mode_count) : '0;
                    drop_out_next    = drop_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        scan_idx_reg    <= scan_idx_next;
        pend_idx_reg    <= pend_idx_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        cnt_reg         <= cnt_next;
        drop_reg        <= drop_next;
        was_present_reg <= was_present_next;
        id_count_reg    <= id_count_next;
        best_id_reg     <= best_id_next;
        best_count_reg  <= best_count_next;
        best_valid_reg  <= best_valid_next;
        drop_out_reg    <= drop_out_next;
    end

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign was_present     = was_present_reg;
    assign id_count        = id_count_reg;
    assign best_id         = best_id_reg;
    assign best_count      = best_count_reg;
    assign best_valid      = best_valid_reg;
    assign table_full_drop = drop_out_reg;

    `IOC_ASSERT_SAME(a_used_in_range, 1'b1, used_reg <= USED_BITS'(TABLE_DEPTH))
    `IOC_ASSERT_NEXT(a_accept_starts_scan, in_take, state_reg == ST_SCAN)
    `IOC_ASSERT_SAME(a_write_only_in_write, ram_we, state_reg == ST_WRITE && !drop_reg)
    `IOC_ASSERT_SAME(a_drop_not_present, out_valid_reg && drop_out_reg, !was_present_reg)
    `IOC_ASSERT_SAME(a_drop_zero_count, out_valid_reg && drop_out_reg, id_count_reg == '0)
endmodule
`default_nettype wire

>>> rtl/core/ioc_table_ram.sv
// single port write, single port read table memory with registered read
`timescale 1ns / 1ps
`default_nettype none
module ioc_table_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/ioc_mode_track.sv
// running mode register: greatest count, smallest id on ties
`timescale 1ns / 1ps
`default_nettype none
module ioc_mode_track (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ioc_pkg::mode_upd_t            upd,
    output logic      [ioc_pkg::KEY_BITS-1:0]  mode_id,
    output logic      [ioc_pkg::COUNT_BITS-1:0] mode_count
);
    import ioc_pkg::*;

    logic [KEY_BITS-1:0]   mode_id_reg;
    logic [COUNT_BITS-1:0] mode_count_reg;
    logic                  better;

    assign better = (upd.cnt > mode_count_reg) ||
                    ((upd.cnt == mode_count_reg) && (upd.id < mode_id_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_id_reg    <= '0;
            mode_count_reg <= '0;
        end
        else if (upd.clear)
        begin
            mode_id_reg    <= '0;
            mode_count_reg <= '0;
        end
        else if (upd.valid && better)
        begin
            mode_id_reg    <= upd.id;
            mode_count_reg <= upd.cnt;
        end
    end

    assign mode_id    = mode_id_reg;
    assign mode_count = mode_count_reg;
endmodule
`default_nettype wire

>>> tb/tb_id_occurrence_counter_with_mode_unit.sv
// testbench for the id occurrence counter with running mode
`timescale 1ns / 1ps

import ioc_pkg::*;

typedef struct packed {
    logic                      was_present;
    logic [OUT_COUNT_BITS-1:0] id_count;
    logic [KEY_BITS-1:0]       best_id;
    logic [OUT_COUNT_BITS-1:0] best_count;
    logic                      best_valid;
    logic                      full_drop;
} tally_report_t;

class occurrence_tally;
    logic [KEY_BITS-1:0]   keys [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] counts [TABLE_DEPTH];
    int                    used;
    logic [KEY_BITS-1:0]   lead_id;
    logic [COUNT_BITS-1:0] lead_count;
    tally_report_t         expected_reports [$];
    int                    mismatches;

    function new();
        used = 0;
        lead_id = '0;
        lead_count = '0;
        mismatches = 0;
    endfunction

    // predict the report for one accepted input beat
    function void note_item(logic [KEY_BITS-1:0] id, logic fresh);
        tally_report_t         rep;
        logic [COUNT_BITS-1:0] cnt;
        int                    slot;
        int                    i;
        if (fresh)
        begin
            used = 0;
            lead_id = '0;
            lead_count = '0;
        end
        slot = -1;
        for (i = 0; i < used; i++)
            if (slot < 0 && keys[i] == id)
                slot = i;
        rep = '0;
        cnt = '0;
        if (slot >= 0)
        begin
            cnt = counts[slot];
            if (cnt != COUNT_MAX)
                cnt = cnt + 1'b1;
            counts[slot] = cnt;
            rep.was_present = 1'b1;
        end
        else if (used < TABLE_DEPTH)
        begin
            keys[used] = id;
            counts[used] = COUNT_BITS'(1);
            used++;
            cnt = COUNT_BITS'(1);
        end
        else
        begin
            rep.full_drop = 1'b1;
        end
        // ties go to the smaller id
        if (!rep.full_drop && (cnt > lead_count || (cnt == lead_count && id < lead_id)))
        begin
            lead_id = id;
            lead_count = cnt;
        end
        rep.id_count = cnt[OUT_COUNT_BITS-1:0];
        if (used > 0)
        begin
            rep.best_id = lead_id;
            rep.best_count = lead_count[OUT_COUNT_BITS-1:0];
            rep.best_valid = 1'b1;
        end
        expected_reports.insert(expected_reports.size(), rep);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatches++;
        end
    endfunction

    function void check_report(logic was_present, logic [OUT_COUNT_BITS-1:0] id_count,
                               logic [KEY_BITS-1:0] best_id,
                               logic [OUT_COUNT_BITS-1:0] best_count,
                               logic best_valid, logic full_drop);
        tally_report_t want;
        if (expected_reports.size() == 0)
        begin
            $error("output beat with no input beat pending");
            mismatches++;
        end
        else
        begin
            want = expected_reports.pop_front();
            check_field("was_present", want.was_present, was_present);
            check_field("id_count", want.id_count, id_count);
            check_field("best_id", want.best_id, best_id);
            check_field("best_count", want.best_count, best_count);
            check_field("best_valid", want.best_valid, best_valid);
            check_field("table_full_drop", want.full_drop, full_drop);
        end
    endfunction
endclass

module tb_id_occurrence_counter_with_mode_unit;
    localparam int unsigned CYCLE_LIMIT = 30_000_000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [KEY_BITS-1:0]       item_id = '0;
    logic                      start_new = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      was_present;
    logic [OUT_COUNT_BITS-1:0] id_count;
    logic [KEY_BITS-1:0]       best_id;
    logic [OUT_COUNT_BITS-1:0] best_count;
    logic                      best_valid;
    logic                      table_full_drop;

    bit                        quiet = 1'b0;
    int                        hold_left = 0;
    int unsigned               cycle_count = 0;
    occurrence_tally           tally;

    id_occurrence_counter_with_mode_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .item_id         (item_id),
        .start_new       (start_new),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .was_present     (was_present),
        .id_count        (id_count),
        .best_id         (best_id),
        .best_count      (best_count),
        .best_valid      (best_valid),
        .table_full_drop (table_full_drop)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // random output stall bursts; no new burst starts once quiet is set
    always @(posedge clk)
    begin
        if (!quiet && hold_left == 0 && $urandom_range(0, 99) < 8)
        begin
            out_stall <= 1'b1;
            hold_left <= $urandom_range(0, 12);
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tally.note_item(item_id, start_new);
            if (out_valid && !out_stall)
                tally.check_report(was_present, id_count, best_id, best_count, best_valid,
                                   table_full_drop);
        end
    end

    function automatic logic [KEY_BITS-1:0] pick_id();
        case ($urandom_range(0, 3))
            0: pick_id = $urandom_range(0, 15);
            1: pick_id = '1 - $urandom_range(0, 3);
            default: pick_id = $urandom();
        endcase
    endfunction

    task automatic send_beat(input logic [KEY_BITS-1:0] id, input logic fresh);
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        item_id   <= id;
        start_new <= fresh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        logic [KEY_BITS-1:0] pool [TABLE_DEPTH + 8];
        int                  pool_size;
        int                  run_len;
        int                  kind;
        int                  n;
        int                  k;
        tally = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(32'h0000_0003, 1'b0);
        send_beat(32'h0000_0000, 1'b1);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b0);
        // tie at two, smaller id takes the lead
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'hAAAA_AAAA, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'hAAAA_AAAA, 1'b1);
        send_beat(32'hAAAA_AAAA, 1'b1);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'hAAAA_AAAA, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'h0000_0001, 1'b0);

        n = 0;
        while (n < 1500)
        begin
            if (n >= 1200)
                quiet = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                // small pool, lots of repeats and ties
                pool_size = $urandom_range(1, 10);
                for (k = 0; k < pool_size; k++)
                    pool[k] = pick_id();
                run_len = $urandom_range(4, 40);
                for (k = 0; k < run_len; k++)
                    send_beat(pool[$urandom_range(0, pool_size - 1)], k == 0);
            end
            else if (kind < 8)
            begin
                // fill the table, then push new ids against it
                pool_size = TABLE_DEPTH + $urandom_range(1, 8);
                for (k = 0; k < pool_size; k++)
                    pool[k] = $urandom();
                for (k = 0; k < pool_size; k++)
                    send_beat(pool[k], k == 0);
                run_len = $urandom_range(5, 30);
                for (k = 0; k < run_len; k++)
                    send_beat(pool[$urandom_range(0, pool_size - 1)], 1'b0);
                run_len += pool_size;
            end
            else
            begin
                run_len = $urandom_range(5, 60);
                for (k = 0; k < run_len; k++)
                    send_beat(pick_id(), $urandom_range(0, 19) == 0);
            end
            n += run_len;
        end
        in_valid <= 1'b0;

        while (tally.expected_reports.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (tally.mismatches == 0 && tally.expected_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ioc_pkg.sv
rtl/core/ioc_table_ram.sv
rtl/core/ioc_mode_track.sv
rtl/core/id_occurrence_counter_with_mode_unit.sv
tb/tb_id_occurrence_counter_with_mode_unit.sv
